### rtl/sha1_pkg.sv
// Shared types, constants and helper functions of the SHA-1 hash engine.
package sha1_pkg;

   typedef logic [31:0] word_type;

   // Working variables a..e of one compression.
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } vars_type;

   // Commands from the sequencer to the message schedule.
   typedef struct packed {
      logic       byte_en;
      logic [7:0] byte_val;
      logic       word_en;
      word_type   word_val;
      logic       round_en;
   } sched_ctrl_type;

   localparam int DIGEST_WORDS = 5;
   localparam int SCHED_WORDS  = 16;
   localparam int ROUND_COUNT  = 80;
   localparam int ROUND_W      = 7;
   localparam int POS_W        = 6;

   localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUND_COUNT - 1);
   localparam logic [POS_W-1:0]   POS_LAST   = '1;
   localparam logic [POS_W-1:0]   LEN_POS    = POS_W'(56);
   localparam logic [7:0]         PAD_BYTE   = 8'h80;

   localparam word_type H_INIT [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam word_type K_0 = 32'h5A827999;
   localparam word_type K_1 = 32'h6ED9EBA1;
   localparam word_type K_2 = 32'h8F1BBCDC;
   localparam word_type K_3 = 32'hCA62C1D6;

   // Round constant for round t; each constant covers twenty rounds.
   function automatic word_type round_const(input logic [ROUND_W-1:0] t);
      word_type k;
      if (t < ROUND_W'(20)) begin
         k = K_0;
      end else if (t < ROUND_W'(40)) begin
         k = K_1;
      end else if (t < ROUND_W'(60)) begin
         k = K_2;
      end else begin
         k = K_3;
      end
      return k;
   endfunction

endpackage

### rtl/sha1_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
interface sha1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output has_byte,
                   output end_of_message, input ready);
   modport sink (input valid, input data_byte, input has_byte,
                 input end_of_message, output ready);
endinterface

interface sha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

### rtl/sha1_round.sv
// One SHA-1 compression round, shared by all eighty rounds of a block.
module sha1_round (
   input  sha1_pkg::vars_type                     cur,
   input  sha1_pkg::word_type                     w,
   input  logic [sha1_pkg::ROUND_W-1:0]           t,
   output sha1_pkg::vars_type                     nxt
);
   import sha1_pkg::*;

   word_type f;
   word_type tmp;

   // Round function depends on which group of twenty rounds this is.
   always_comb begin
      if (t < ROUND_W'(20)) begin
         f = (cur.b & cur.c) | (~cur.b & cur.d);
      end else if (t < ROUND_W'(40)) begin
         f = cur.b ^ cur.c ^ cur.d;
      end else if (t < ROUND_W'(60)) begin
         f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      end else begin
         f = cur.b ^ cur.c ^ cur.d;
      end
   end

   assign tmp = {cur.a[26:0], cur.a[31:27]} + f + cur.e + w + round_const(t);

   // Rotate the working variables.
   always_comb begin
      nxt.a = tmp;
      nxt.b = cur.a;
      nxt.c = {cur.b[1:0], cur.b[31:2]};
      nxt.d = cur.c;
      nxt.e = cur.d;
   end

endmodule

### rtl/sha1_sched.sv
// Message schedule: packs bytes into a 16-word shift line and expands it per round.
module sha1_sched (
   input  logic                               clock,
   input  logic                               reset,
   input  sha1_pkg::sched_ctrl_type           ctrl,
   output sha1_pkg::word_type                 w_cur,
   output logic [sha1_pkg::POS_W-1:0]         pos
);
   import sha1_pkg::*;

   word_type              line_ff [SCHED_WORDS];
   word_type              line_in [SCHED_WORDS];
   logic [23:0]           acc_ff, acc_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   word_type              expand_x;
   word_type              shift_word;
   logic                  shift_en;

   // Line entry j holds W[t+j] during round t, so the taps are fixed.
   assign expand_x = line_ff[13] ^ line_ff[8] ^ line_ff[2] ^ line_ff[0];

   // Select what enters the line and advance the block position.
   always_comb begin
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      shift_en   = 1'b0;
      shift_word = {expand_x[30:0], expand_x[31]};
      if (ctrl.round_en) begin
         shift_en = 1'b1;
      end else if (ctrl.word_en) begin
         shift_en   = 1'b1;
         shift_word = ctrl.word_val;
         pos_in     = pos_ff + POS_W'(4);
      end else if (ctrl.byte_en) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff[1:0] == 2'd3) begin
            shift_en   = 1'b1;
            shift_word = {acc_ff, ctrl.byte_val};
         end else begin
            acc_in = {acc_ff[15:0], ctrl.byte_val};
         end
      end
   end

   // Shift the line by one word.
   always_comb begin
      for (int i = 0; i < SCHED_WORDS - 1; i++) begin
         line_in[i] = shift_en ? line_ff[i+1] : line_ff[i];
      end
      line_in[SCHED_WORDS-1] = shift_en ? shift_word : line_ff[SCHED_WORDS-1];
   end

   // Block position is control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      line_ff <= line_in;
   end

   assign w_cur = line_ff[0];
   assign pos   = pos_ff;

endmodule

### rtl/sha1_hash_engine_unit.sv
// Top level of the SHA-1 hash engine: sequencer, chain value and digest output.
//
//   channel    dir  handshake               payload
//   req_chan   in   valid/ready             data_byte[7:0], has_byte, end_of_message
//   rsp_chan   out  valid/ready             digest_word[31:0], word_index[2:0], last_word
//
// A byte that fills a 64-byte block starts a compression: one round per cycle
// through the shared round unit, then the chain add.
// End of message pads one byte per cycle up to position 56, writes the length as
// two words, runs one or two more compressions, then offers five digest words.
// Reset is synchronous; no clearing pass is needed.
// The input is not ready while a block compresses, pads or the digest is out;
// a stalled digest word holds until taken.
module sha1_hash_engine_unit (
   input  logic        clock,
   input  logic        reset,
   sha1_req_if.sink    req_chan,
   sha1_rsp_if.source  rsp_chan
);
   import sha1_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_COMPRESS,
      ST_FINAL,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   state_type           ret_ff, ret_in;
   logic [ROUND_W-1:0]  round_ff, round_in;
   logic [2:0]          idx_ff, idx_in;
   logic                pad_zero_ff, pad_zero_in;
   logic [31:0]         byte_count_ff, byte_count_in;
   word_type            chain_ff [DIGEST_WORDS];
   word_type            chain_in [DIGEST_WORDS];
   vars_type            vars_ff, vars_in;
   vars_type            round_out;
   vars_type            chain_vars;
   sched_ctrl_type      sched_ctrl;
   word_type            w_cur;
   logic [POS_W-1:0]    pos;
   logic                last_idx;

   sha1_sched u_sched (
      .clock (clock),
      .reset (reset),
      .ctrl  (sched_ctrl),
      .w_cur (w_cur),
      .pos   (pos)
   );

   sha1_round u_round (
      .cur (vars_ff),
      .w   (w_cur),
      .t   (round_ff),
      .nxt (round_out)
   );

   // Chain value in working-variable form, loaded at the start of a block.
   always_comb begin
      chain_vars.a = chain_ff[0];
      chain_vars.b = chain_ff[1];
      chain_vars.c = chain_ff[2];
      chain_vars.d = chain_ff[3];
      chain_vars.e = chain_ff[4];
   end

   assign last_idx = (idx_ff == 3'(DIGEST_WORDS - 1));

   // Channel outputs.
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_EMIT);
   assign rsp_chan.digest_word = chain_ff[idx_ff];
   assign rsp_chan.word_index  = idx_ff;
   assign rsp_chan.last_word   = last_idx;

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      round_in      = round_ff;
      idx_in        = idx_ff;
      pad_zero_in   = pad_zero_ff;
      byte_count_in = byte_count_ff;
      chain_in      = chain_ff;
      vars_in       = vars_ff;
      sched_ctrl    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.has_byte) begin
                  sched_ctrl.byte_en  = 1'b1;
                  sched_ctrl.byte_val = req_chan.data_byte;
                  byte_count_in       = byte_count_ff + 32'd1;
               end
               pad_zero_in = 1'b0;
               if (req_chan.has_byte && pos == POS_LAST) begin
                  state_in = ST_COMPRESS;
                  round_in = '0;
                  vars_in  = chain_vars;
                  ret_in   = req_chan.end_of_message ? ST_PAD : ST_IDLE;
               end else if (req_chan.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // Marker byte first, then zeros up to the length field.
            sched_ctrl.byte_en  = 1'b1;
            sched_ctrl.byte_val = pad_zero_ff ? 8'h00 : PAD_BYTE;
            pad_zero_in         = 1'b1;
            if (pos == POS_LAST) begin
               state_in = ST_COMPRESS;
               round_in = '0;
               vars_in  = chain_vars;
               ret_in   = ST_PAD;
            end else if (pos == LEN_POS - POS_W'(1)) begin
               state_in = ST_LEN_HI;
            end
         end
         ST_LEN_HI: begin
            sched_ctrl.word_en  = 1'b1;
            sched_ctrl.word_val = {29'd0, byte_count_ff[31:29]};
            state_in            = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            sched_ctrl.word_en  = 1'b1;
            sched_ctrl.word_val = {byte_count_ff[28:0], 3'd0};
            state_in            = ST_COMPRESS;
            round_in            = '0;
            vars_in             = chain_vars;
            ret_in              = ST_EMIT;
         end
         ST_COMPRESS: begin
            sched_ctrl.round_en = 1'b1;
            vars_in             = round_out;
            round_in            = round_ff + ROUND_W'(1);
            if (round_ff == ROUND_LAST) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            chain_in[0] = chain_ff[0] + vars_ff.a;
            chain_in[1] = chain_ff[1] + vars_ff.b;
            chain_in[2] = chain_ff[2] + vars_ff.c;
            chain_in[3] = chain_ff[3] + vars_ff.d;
            chain_in[4] = chain_ff[4] + vars_ff.e;
            idx_in      = '0;
            state_in    = ret_ff;
         end
         ST_EMIT: begin
            if (rsp_chan.ready) begin
               if (last_idx) begin
                  chain_in      = H_INIT;
                  byte_count_in = '0;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         round_ff      <= '0;
         idx_ff        <= '0;
         pad_zero_ff   <= 1'b0;
         byte_count_ff <= '0;
         chain_ff      <= H_INIT;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         round_ff      <= round_in;
         idx_ff        <= idx_in;
         pad_zero_ff   <= pad_zero_in;
         byte_count_ff <= byte_count_in;
         chain_ff      <= chain_in;
      end
   end

   // Working variables are payload only.
   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
   end

   // The two sides never handshake at once.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input ready while a digest word is offered");

   // The round counter stays within the eighty rounds.
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPRESS) |-> (round_ff <= ROUND_LAST))
      else $error("round counter out of range");

   // The length field always starts at its fixed block position.
   a_len_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN_HI) |-> (pos == LEN_POS))
      else $error("length field misaligned");

   // After the last digest word the engine is back at the initial chain value.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_word) |=>
      (byte_count_ff == 32'd0 && chain_ff[0] == H_INIT[0] && pos == '0))
      else $error("engine not restarted after digest");

endmodule

### tb/tb.sv
// Self-checking testbench of the SHA-1 hash engine with a scoreboard that predicts each digest.
module tb;
   import sha1_pkg::*;

   // Scoreboard: a SHA-1 predictor fed by accepted byte words, and the digest words it owes.
   class sha1_digest_board;
      typedef struct {
         word_type   word;
         logic [2:0] index;
         logic       last;
      } digest_entry_type;

      word_type         chain [DIGEST_WORDS];
      word_type         sched [SCHED_WORDS];
      logic [31:0]      byte_total;
      digest_entry_type owed_words [$];
      int unsigned      mismatches;

      function new();
         foreach (sched[i]) sched[i] = '0;
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         foreach (chain[i]) chain[i] = H_INIT[i];
         byte_total = '0;
      endfunction

      // Bytes are packed big-endian into the sixteen schedule words.
      function void place_byte(logic [5:0] pos, logic [7:0] value);
         sched[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = value;
      endfunction

      // Eighty rounds over the current block, expanding the schedule in place.
      function void compress_block();
         word_type a, b, c, d, e, f, k, tmp, x;
         int s;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int t = 0; t < ROUND_COUNT; t++) begin
            s = t % 16;
            if (t >= 16) begin
               x = sched[(s + 13) % 16] ^ sched[(s + 8) % 16] ^ sched[(s + 2) % 16] ^ sched[s];
               sched[s] = {x[30:0], x[31]};
            end
            if (t < 20) begin
               f = (b & c) | (~b & d);
               k = K_0;
            end else if (t < 40) begin
               f = b ^ c ^ d;
               k = K_1;
            end else if (t < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = K_2;
            end else begin
               f = b ^ c ^ d;
               k = K_3;
            end
            tmp = {a[26:0], a[31:27]} + f + e + sched[s] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      // Takes one accepted input word; at end of message it queues the five digest words.
      function void note_word(logic [7:0] data, logic has, logic eom);
         logic [5:0]       pos;
         logic [63:0]      bit_len;
         digest_entry_type entry;
         if (has) begin
            pos = byte_total[5:0];
            place_byte(pos, data);
            byte_total++;
            if (pos == POS_LAST) begin
               compress_block();
            end
         end
         if (!eom) begin
            return;
         end
         pos = byte_total[5:0];
         place_byte(pos, PAD_BYTE);
         for (int p = int'(pos) + 1; p < 64; p++) begin
            place_byte(6'(p), 8'h00);
         end
         // No room left for the length: finish this block and start a blank one.
         if (pos >= LEN_POS) begin
            compress_block();
            foreach (sched[i]) sched[i] = '0;
         end
         bit_len = {32'h0, byte_total} << 3;
         sched[14] = bit_len[63:32];
         sched[15] = bit_len[31:0];
         compress_block();
         for (int w = 0; w < DIGEST_WORDS; w++) begin
            entry.word  = chain[w];
            entry.index = 3'(w);
            entry.last  = (w == DIGEST_WORDS - 1);
            owed_words.push_back(entry);
         end
         restart();
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      // Compares one accepted digest word with the oldest owed one.
      task check_word(word_type word, logic [2:0] index, logic last);
         digest_entry_type want;
         if (owed_words.size() == 0) begin
            report($sformatf("digest word %h index %0d arrived with none owed", word, index));
            return;
         end
         want = owed_words.pop_front();
         if (word !== want.word) begin
            report($sformatf("digest word %0d is %h, predicted %h", want.index, word, want.word));
         end
         if (index !== want.index) begin
            report($sformatf("word index is %0d, predicted %0d", index, want.index));
         end
         if (last !== want.last) begin
            report($sformatf("last marker on word %0d is %b, predicted %b",
                             want.index, last, want.last));
         end
      endtask
   endclass

   localparam int ITEM_TARGET = 420;
   localparam int IDLE_PCT    = 23;
   localparam int TAIL_CYCLES = 300;

   logic clock;
   logic reset;

   sha1_req_if req_chan ();
   sha1_rsp_if rsp_chan ();

   sha1_hash_engine_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sha1_digest_board board = new();
   int unsigned      items_sent;
   logic             steady;

   // Lengths that put the pad byte and the length field on block boundaries.
   int boundary_lengths [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   // Offers one word and returns at the edge where it is taken.
   task automatic send_word(input logic [7:0] data, input logic has, input logic eom);
      steady = (items_sent >= 180 && items_sent < 280);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.data_byte      <= data;
      req_chan.has_byte       <= has;
      req_chan.end_of_message <= eom;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      board.note_word(data, has, eom);
      if (has || eom) begin
         items_sent++;
      end
   endtask

   // Holds the input off until every owed digest word has come out.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.owed_words.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // One message of random bytes, sometimes with empty words mixed in.
   // The end marker rides on the last byte or comes in an empty word of its own.
   task automatic send_message(input int len, input bit separate_end);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(19) == 0) begin
            send_word(8'($urandom), 1'b0, 1'b0);
         end
         send_word(8'($urandom), 1'b1, (i == len - 1) && !separate_end);
      end
      if (len == 0 || separate_end) begin
         send_word(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   // Digest words are taken with random backpressure.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            board.check_word(rsp_chan.digest_word, rsp_chan.word_index, rsp_chan.last_word);
         end
         rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      int len;
      items_sent              = 0;
      steady                  = 1'b0;
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.data_byte      <= 8'h00;
      req_chan.has_byte       <= 1'b0;
      req_chan.end_of_message <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty words, which the block must ignore.
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      // Empty message.
      send_word(8'h00, 1'b0, 1'b1);
      // "abc" with the end marker on the last byte.
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      // One byte together with the end marker.
      send_word(8'hFF, 1'b1, 1'b1);
      // One byte, then the end in an empty word whose data must be ignored.
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hA5, 1'b0, 1'b1);
      // Byte extremes and the pad value itself as message data.
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'h80, 1'b1, 1'b0);
      send_word(8'h7F, 1'b1, 1'b1);
      wait_drained();

      // Random messages, mostly short, some around the block boundaries.
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(9) < 7) begin
            len = $urandom_range(20);
         end else begin
            len = boundary_lengths[$urandom_range(7)];
         end
         send_message(len, $urandom_range(3) == 0);
         if ($urandom_range(4) == 0) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.owed_words.size() != 0) begin
         board.report($sformatf("%0d digest words never arrived", board.owed_words.size()));
      end
      if (board.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #3000000;
      $display("FAILURE");
      $finish;
   end

endmodule
